@@ hw/rtl/pakst_pkg.sv @@
// ---------------------------------------------------------------------------
// pakst_pkg
// Shared types, constants and helper functions of the kinematic step unit.
// ---------------------------------------------------------------------------
package pakst_pkg;

    // Width of the shared CORDIC datapath (signed x and y)
    localparam int CW = 36;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T1,
        ST_T2,
        ST_S1,
        ST_S2,
        ST_SPD,
        ST_P,
        ST_ROT0,
        ST_ROT,
        ST_MX,
        ST_MY,
        ST_UY,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_SQRT,
        ST_VEC0,
        ST_VEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_ctrl_t;

    // Arctangent of 2^-i in 32-bit binary angle units
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/pakst_cordic.sv @@
// ---------------------------------------------------------------------------
// pakst_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ---------------------------------------------------------------------------
module pakst_cordic
    import pakst_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_ctrl_t         ctrl,
    input  logic signed [CW-1:0] x_init,
    input  logic signed [CW-1:0] y_init,
    input  logic [31:0]          z_init,
    output logic signed [CW-1:0] x_res,
    output logic signed [CW-1:0] y_res,
    output logic [31:0]          z_res,
    output logic                 done
);

    localparam int IW = $clog2(ITERATIONS);
    localparam logic [IW-1:0] LAST = IW'(ITERATIONS - 1);

    logic signed [CW-1:0] x_reg, y_reg;
    logic [31:0]          z_reg;
    logic [IW-1:0]        iter_reg;
    logic                 busy_reg, done_reg, vec_reg;

    logic signed [CW-1:0] xs, ys;
    logic [31:0]          ang;
    logic                 ccw;

    // Select micro-rotation direction and shifted terms
    always_comb
    begin
        xs  = x_reg >>> iter_reg;
        ys  = y_reg >>> iter_reg;
        ang = atan_entry(5'(iter_reg));
        ccw = vec_reg ? !(y_reg > 0) : !z_reg[31];
    end

    // Load, iterate and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            // Raise done for one cycle after the last micro-rotation
            done_reg <= busy_reg && !ctrl.start && (iter_reg == LAST);
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                vec_reg  <= ctrl.vectoring;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            if (ccw)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign x_res = x_reg;
    assign y_res = y_reg;
    assign z_res = z_reg;
    assign done  = done_reg;

endmodule

@@ hw/rtl/planar_agent_kinematic_step_unit.sv @@
// ---------------------------------------------------------------------------
// planar_agent_kinematic_step_unit
// One tick of a fixed-point planar unicycle integrator with range and bearing.
// ---------------------------------------------------------------------------
// From acceptance to result a transaction makes nine passes through the
// single shared 32x32 multiplier, two runs of the iterative CORDIC (rotation
// for the step direction, vectoring for the bearing) at one micro-rotation
// a cycle, and a 32-step bit-serial square root for the range. in_stall
// is high while a tick is in work; a finished result sits in an output
// register, so the next tick is taken while the previous result waits for
// the consumer. Writes to start_x, start_y, start_heading and start_speed
// also load the live position, heading and speed.
module planar_agent_kinematic_step_unit
    import pakst_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int POS_FRAC_BITS     = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] turn_command,
    input  logic signed [15:0] accel_command,
    input  logic signed [15:0] turn_offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [15:0] heading_out,
    output logic signed [15:0] turn_applied,
    output logic signed [31:0] speed_out,
    output logic [31:0]        range_from_origin,
    output logic signed [15:0] bearing
);

    localparam logic [63:0] K_Q30  = 64'd652032874;
    localparam int          KSH    = 30 - POS_FRAC_BITS;
    localparam logic [63:0] K_INIT = (K_Q30 + (64'd1 << (KSH - 1))) >> KSH;
    localparam logic [63:0] P_HALF = 64'd1 << (POS_FRAC_BITS - 1);

    localparam logic [2:0] IDX_TURN_GAIN  = 3'd0;
    localparam logic [2:0] IDX_SPEED_GAIN = 3'd1;
    localparam logic [2:0] IDX_TIME_STEP  = 3'd2;
    localparam logic [2:0] IDX_PIPE_MODE  = 3'd3;
    localparam logic [2:0] IDX_START_X    = 3'd4;
    localparam logic [2:0] IDX_START_Y    = 3'd5;
    localparam logic [2:0] IDX_START_HEAD = 3'd6;
    localparam logic [2:0] IDX_START_SPD  = 3'd7;

    state_t state_reg, state_next;

    // Configuration
    logic [15:0] turn_gain_reg, time_step_reg;
    logic [31:0] speed_gain_reg;
    logic        pipe_mode_reg;

    // Kinematic state
    logic [15:0]        heading_reg;
    logic signed [31:0] speed_reg, x_reg, y_reg;

    // Captured input and intermediates
    logic [15:0]        cmd_reg, scmd_reg, off_reg, turn_reg;
    logic [31:0]        p_mag_reg;
    logic               p_neg_reg, flip_reg;
    logic [63:0]        prod_reg, acc_reg, rad_reg;
    logic [34:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [4:0]         cnt_reg;

    // Output registers
    logic               out_valid_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, speed_out_reg;
    logic [15:0]        heading_out_reg, turn_out_reg, bearing_reg;
    logic [31:0]        range_reg;

    // Shared multiplier and CORDIC hookup
    logic [31:0]          mul_a, mul_b;
    cordic_ctrl_t         cctrl;
    logic signed [CW-1:0] cx_init, cy_init, cx_res, cy_res;
    logic [31:0]          cz_init, cz_res;
    logic                 cdone;

    // Derived magnitudes
    logic [16:0]          cmd_abs, scmd_abs;
    logic [31:0]          speed_abs, x_abs, y_abs;
    logic signed [CW-1:0] c_val, s_val;
    logic [31:0]          c_abs, s_abs;
    logic                 c_neg, s_neg;
    logic                 flip_now;

    pakst_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cctrl),
        .x_init (cx_init),
        .y_init (cy_init),
        .z_init (cz_init),
        .x_res  (cx_res),
        .y_res  (cy_res),
        .z_res  (cz_res),
        .done   (cdone)
    );

    // Form operand magnitudes
    always_comb
    begin
        cmd_abs   = cmd_reg[15]  ? 17'(-{1'b1, cmd_reg})  : {1'b0, cmd_reg};
        scmd_abs  = scmd_reg[15] ? 17'(-{1'b1, scmd_reg}) : {1'b0, scmd_reg};
        speed_abs = speed_reg[31] ? 32'(-speed_reg) : 32'(speed_reg);
        x_abs     = x_reg[31] ? 32'(-x_reg) : 32'(x_reg);
        y_abs     = y_reg[31] ? 32'(-y_reg) : 32'(y_reg);
        c_val     = flip_reg ? -cx_res : cx_res;
        s_val     = flip_reg ? -cy_res : cy_res;
        c_neg     = c_val[CW-1];
        s_neg     = s_val[CW-1];
        c_abs     = c_neg ? 32'(-c_val) : 32'(c_val);
        s_abs     = s_neg ? 32'(-s_val) : 32'(s_val);
        flip_now  = ($signed(heading_reg) > 16'sd16384) ||
                    ($signed(heading_reg) < -16'sd16384);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_S1;
            ST_S1:   state_next = ST_S2;
            ST_S2:   state_next = ST_SPD;
            ST_SPD:  state_next = ST_P;
            ST_P:    state_next = ST_ROT0;
            ST_ROT0: state_next = ST_ROT;
            ST_ROT:  if (cdone) state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_UY;
            ST_UY:   state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == 5'd31) state_next = ST_VEC0;
            ST_VEC0: state_next = ST_VEC;
            ST_VEC:  if (cdone) state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, CORDIC control, input stall
    always_comb
    begin
        mul_a           = '0;
        mul_b           = '0;
        cctrl.start     = 1'b0;
        cctrl.vectoring = 1'b0;
        cx_init         = CW'(K_INIT);
        cy_init         = '0;
        cz_init         = {heading_reg, 16'h0000} ^ {flip_now, 31'h0};
        in_stall        = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_T1:
            begin
                mul_a = {16'h0, time_step_reg};
                mul_b = {15'h0, cmd_abs};
            end
            ST_T2:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {16'h0, turn_gain_reg};
            end
            ST_S1:
            begin
                mul_a = {16'h0, time_step_reg};
                mul_b = {15'h0, scmd_abs};
            end
            ST_S2:
            begin
                mul_a = prod_reg[31:0];
                mul_b = speed_gain_reg;
            end
            ST_P:
            begin
                mul_a = speed_abs;
                mul_b = {16'h0, time_step_reg};
            end
            ST_ROT0:
            begin
                cctrl.start = 1'b1;
            end
            ST_MX:
            begin
                mul_a = p_mag_reg;
                mul_b = c_abs;
            end
            ST_MY:
            begin
                mul_a = p_mag_reg;
                mul_b = s_abs;
            end
            ST_SQX:
            begin
                mul_a = x_abs;
                mul_b = x_abs;
            end
            ST_SQY:
            begin
                mul_a = y_abs;
                mul_b = y_abs;
            end
            ST_VEC0:
            begin
                cctrl.start     = 1'b1;
                cctrl.vectoring = 1'b1;
                cx_init = x_reg[31] ? -CW'(x_reg) : CW'(x_reg);
                cy_init = x_reg[31] ? -CW'(y_reg) : CW'(y_reg);
                cz_init = x_reg[31] ? 32'h8000_0000 : 32'h0;
            end
            default:
            begin
            end
        endcase
    end

    // Shared multiplier with registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath intermediates
    logic [63:0] tsum, ssum, psum, dsum, dmag;
    logic [15:0] tmag16;
    logic [35:0] smag;
    logic signed [65:0] sdelta, ddelta;
    logic        d_neg;
    logic [34:0] rem_sh, rem_test;

    always_comb
    begin
        tsum     = prod_reg + 64'h0800_0000;
        tmag16   = tsum[43:28];
        ssum     = prod_reg + 64'h0800_0000;
        smag     = ssum[63:28];
        sdelta   = scmd_reg[15] ? -$signed({30'h0, smag}) : $signed({30'h0, smag});
        psum     = prod_reg + 64'h8000;
        dsum     = prod_reg + P_HALF;
        dmag     = dsum >> POS_FRAC_BITS;
        d_neg    = (state_reg == ST_MY) ? (p_neg_reg ^ c_neg) : (p_neg_reg ^ s_neg);
        ddelta   = d_neg ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
        rem_sh   = {rem_reg[32:0], rad_reg[63:62]};
        rem_test = {1'b0, root_reg, 2'b01};
    end

    // Configuration, kinematic state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_reg  <= 16'd32768;
            speed_gain_reg <= 32'd655;
            time_step_reg  <= 16'd6554;
            pipe_mode_reg  <= 1'b0;
            heading_reg    <= 16'd0;
            speed_reg      <= 32'sd6554;
            x_reg          <= 32'sd0;
            y_reg          <= 32'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Raise the result when it is loaded; drop it once the consumer takes it
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // Write configuration; start values also load the live state
            if (cfg_we)
            begin
                unique case (cfg_index)
                    IDX_TURN_GAIN:  turn_gain_reg  <= cfg_data[15:0];
                    IDX_SPEED_GAIN: speed_gain_reg <= cfg_data;
                    IDX_TIME_STEP:  time_step_reg  <= cfg_data[15:0];
                    IDX_PIPE_MODE:  pipe_mode_reg  <= cfg_data[0];
                    IDX_START_X:    x_reg          <= cfg_data;
                    IDX_START_Y:    y_reg          <= cfg_data;
                    IDX_START_HEAD: heading_reg    <= cfg_data[15:0];
                    IDX_START_SPD:  speed_reg      <= cfg_data;
                    default:        turn_gain_reg  <= turn_gain_reg;
                endcase
            end
            else
            begin
                unique case (state_reg)
                    ST_S1:
                    begin
                        if (pipe_mode_reg)
                        begin
                            turn_reg    <= off_reg;
                            heading_reg <= heading_reg + off_reg;
                        end
                        else
                        begin
                            turn_reg    <= (cmd_reg[15] ? -tmag16 : tmag16) + off_reg;
                            heading_reg <= heading_reg +
                                           (cmd_reg[15] ? -tmag16 : tmag16) + off_reg;
                        end
                    end
                    ST_SPD:
                    begin
                        speed_reg <= sat32(66'(speed_reg) + sdelta);
                    end
                    ST_MY:
                    begin
                        x_reg <= sat32(66'(x_reg) + ddelta);
                    end
                    ST_UY:
                    begin
                        y_reg <= sat32(66'(y_reg) + ddelta);
                    end
                    ST_DONE:
                    begin
                        if (!out_valid_reg || !out_stall)
                        begin
                            pos_x_reg       <= x_reg;
                            pos_y_reg       <= y_reg;
                            heading_out_reg <= heading_reg;
                            turn_out_reg    <= turn_reg;
                            speed_out_reg   <= speed_reg;
                            range_reg       <= root_reg;
                            bearing_reg     <= (x_reg == 32'sd0 && y_reg == 32'sd0) ?
                                               16'h0000 : 16'((cz_res + 32'h8000) >> 16);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Capture the transaction, step length, squares and bit-serial root
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg  <= turn_command;
                    scmd_reg <= accel_command;
                    off_reg  <= turn_offset;
                end
            end
            ST_ROT0:
            begin
                p_mag_reg <= psum[47:16];
                p_neg_reg <= speed_reg[31];
                flip_reg  <= flip_now;
            end
            ST_SQY:
            begin
                acc_reg <= prod_reg;
            end
            ST_SUM:
            begin
                rad_reg  <= acc_reg + prod_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_sh >= rem_test)
                begin
                    rem_reg  <= rem_sh - rem_test;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign pos_x             = pos_x_reg;
    assign pos_y             = pos_y_reg;
    assign heading_out       = heading_out_reg;
    assign turn_applied      = turn_out_reg;
    assign speed_out         = speed_out_reg;
    assign range_from_origin = range_reg;
    assign bearing           = bearing_reg;

endmodule
